// ----- hw/rtl/psd_pkg.sv -----
// Shared types, constants and field helpers of the pixel sparse state decoder.
`timescale 1ns / 1ps

package psd_pkg;

  localparam int SENSORS_PER_LADDER = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_CHIP_LOW_BIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHIP_END_BIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHIP_HIGH_WEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_FLAG_BIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LOW_BIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_END_BIT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LOW_BIT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_END_BIT    = 3'd7;

  localparam logic [3:0] RST_CHIP_LOW_BIT     = 4'd12;
  localparam logic [4:0] RST_CHIP_END_BIT     = 5'd15;
  localparam logic [6:0] RST_CHIP_HIGH_WEIGHT = 7'd8;
  localparam logic [3:0] RST_ROW_FLAG_BIT     = 4'd15;
  localparam logic [3:0] RST_RUN_LOW_BIT      = 4'd10;
  localparam logic [4:0] RST_RUN_END_BIT      = 5'd12;
  localparam logic [3:0] RST_VALUE_LOW_BIT    = 4'd0;
  localparam logic [4:0] RST_VALUE_END_BIT    = 5'd10;

  localparam logic [15:0] ROW_UNSET = 16'hffff;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ID,
    S_READ,
    S_EMIT
  } psd_state_t;

  // Bits [lo, end) of a 16-bit half; empty or reversed ranges give zero.
  function automatic logic [15:0] take_field(input logic [15:0] half,
                                             input logic [3:0]  lo,
                                             input logic [4:0]  end_bit);
    logic [16:0] mask;
    logic [15:0] keep;
    mask = (17'd1 << end_bit[3:0]) - 17'd1;
    keep = (end_bit >= 5'd16) ? half : (half & mask[15:0]);
    return keep >> lo;
  endfunction

  // Run length code saturated at three.
  function automatic logic [1:0] run_code(input logic [15:0] half,
                                          input logic [3:0]  lo,
                                          input logic [4:0]  end_bit);
    logic [15:0] f;
    f = take_field(half, lo, end_bit);
    return (f > 16'd3) ? 2'd3 : f[1:0];
  endfunction

endpackage

// ----- hw/rtl/psd_in_if.sv -----
// Input channel: one hit word and its sector per transaction.
`timescale 1ns / 1ps

interface psd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] hit_word;
  logic [3:0]  sector_number;

  modport source (output valid, output hit_word, output sector_number, input ready);
  modport sink   (input valid, input hit_word, input sector_number, output ready);
endinterface

// ----- hw/rtl/psd_out_if.sv -----
// Result channel: one fired pixel per transaction.
`timescale 1ns / 1ps

interface psd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] hit_sector;
  logic [2:0] hit_ladder;
  logic [3:0] hit_sensor;
  logic [9:0] hit_row;
  logic [9:0] hit_column;
  logic       last_hit;

  modport source (output valid, output hit_sector, output hit_ladder, output hit_sensor,
                  output hit_row, output hit_column, output last_hit, input ready);
  modport sink   (input valid, input hit_sector, input hit_ladder, input hit_sensor,
                  input hit_row, input hit_column, input last_hit, output ready);
endinterface

// ----- hw/rtl/pixel_sparse_state_decoder.sv -----
// Top level of the pixel sparse state decoder.
`timescale 1ns / 1ps

// Decodes 32-bit sparse readout words into pixel hits. Each word is taken in
// the idle state; the chip id is formed and checked in the next cycle, which
// also issues the read of that sensor's stored row from the row memory; in
// the cycle after that the row is available, any row state is written back
// and the hit counts of both halves are fixed. Hits then leave through the
// output register at one per cycle while the sink is ready. last_hit marks
// the final hit of a word. Stored rows read as all ones until first written.
module pixel_sparse_state_decoder #(
  parameter int SECTORS = 10,
  parameter int LADDERS = 4,
  parameter int ROWS    = 928,
  parameter int COLUMNS = 960
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [psd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  psd_in_if.sink                          in_ch,
  psd_out_if.source                       out_ch
);

  localparam int CHIP_COUNT = LADDERS * psd_pkg::SENSORS_PER_LADDER;
  localparam int CHIP_W     = $clog2(CHIP_COUNT);

  // configuration
  logic [3:0] chip_low_r, row_flag_r, run_low_r, val_low_r;
  logic [4:0] chip_end_r, run_end_r, val_end_r;
  logic [6:0] weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_low_r <= psd_pkg::RST_CHIP_LOW_BIT;
      chip_end_r <= psd_pkg::RST_CHIP_END_BIT;
      weight_r   <= psd_pkg::RST_CHIP_HIGH_WEIGHT;
      row_flag_r <= psd_pkg::RST_ROW_FLAG_BIT;
      run_low_r  <= psd_pkg::RST_RUN_LOW_BIT;
      run_end_r  <= psd_pkg::RST_RUN_END_BIT;
      val_low_r  <= psd_pkg::RST_VALUE_LOW_BIT;
      val_end_r  <= psd_pkg::RST_VALUE_END_BIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psd_pkg::REG_CHIP_LOW_BIT:     chip_low_r <= cfg_wdata[3:0];
        psd_pkg::REG_CHIP_END_BIT:     chip_end_r <= cfg_wdata[4:0];
        psd_pkg::REG_CHIP_HIGH_WEIGHT: weight_r   <= cfg_wdata;
        psd_pkg::REG_ROW_FLAG_BIT:     row_flag_r <= cfg_wdata[3:0];
        psd_pkg::REG_RUN_LOW_BIT:      run_low_r  <= cfg_wdata[3:0];
        psd_pkg::REG_RUN_END_BIT:      run_end_r  <= cfg_wdata[4:0];
        psd_pkg::REG_VALUE_LOW_BIT:    val_low_r  <= cfg_wdata[3:0];
        psd_pkg::REG_VALUE_END_BIT:    val_end_r  <= cfg_wdata[4:0];
      endcase
    end
  end

  psd_pkg::psd_state_t state_r, state_nxt;

  logic        in_acc;
  logic [31:0] word_r;
  logic [3:0]  sector_r;

  // chip id decode
  logic [15:0]       f_lo, f_hi;
  logic [22:0]       prod;
  logic [23:0]       chip_id_full;
  logic              id_ok;
  logic [CHIP_W-1:0] chip_id;
  logic [2:0]        ladder_idx;
  logic [CHIP_W-1:0] chip_r;
  logic [2:0]        ladder_r;
  logic [3:0]        sensor_r;
  logic [1:0]        is_row_r;
  logic [15:0]       value_r [2];
  logic [1:0]        run_r   [2];

  // row memory
  logic [15:0]           row_mem [CHIP_COUNT];
  logic [CHIP_COUNT-1:0] row_vld_r;
  logic [15:0]           rd_data_r;
  logic                  rd_vld_r;
  logic                  mem_re, mem_we;
  logic [15:0]           stored_row, row_hi, new_row;

  // emission
  logic              sector_ok;
  logic [2:0]        cnt_nxt [2];
  logic [2:0]        cnt_r   [2];
  logic [9:0]        row_r   [2];
  logic              h_r;
  logic [1:0]        c_r;
  logic [2:0]        c_plus;
  logic              emit_load, emit_last, half_done;
  logic [15:0]       col_sum;
  logic              out_valid_r;

  assign in_ch.ready = (state_r == psd_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      word_r   <= in_ch.hit_word;
      sector_r <= in_ch.sector_number;
    end
  end

  assign f_lo         = psd_pkg::take_field(word_r[15:0], chip_low_r, chip_end_r);
  assign f_hi         = psd_pkg::take_field(word_r[31:16], chip_low_r, chip_end_r);
  assign prod         = 23'(f_hi) * 23'(weight_r);
  assign chip_id_full = {8'd0, f_lo} + {1'b0, prod};
  assign id_ok        = (chip_id_full != 24'd0) && (chip_id_full <= 24'(CHIP_COUNT));
  assign chip_id      = CHIP_W'(chip_id_full - 24'd1);

  always_comb begin
    ladder_idx = 3'd0;
    for (int i = 1; i < LADDERS; i++) begin
      if (CHIP_W'(i * psd_pkg::SENSORS_PER_LADDER) <= chip_id) ladder_idx = 3'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == psd_pkg::S_ID) begin
      chip_r      <= chip_id;
      ladder_r    <= ladder_idx + 3'd1;
      sensor_r    <= 4'(chip_id - CHIP_W'(ladder_idx) *
                        CHIP_W'(psd_pkg::SENSORS_PER_LADDER)) + 4'd1;
      is_row_r[0] <= word_r[row_flag_r];
      is_row_r[1] <= word_r[5'(row_flag_r) + 5'd16];
      value_r[0]  <= psd_pkg::take_field(word_r[15:0], val_low_r, val_end_r);
      value_r[1]  <= psd_pkg::take_field(word_r[31:16], val_low_r, val_end_r);
      run_r[0]    <= psd_pkg::run_code(word_r[15:0], run_low_r, run_end_r);
      run_r[1]    <= psd_pkg::run_code(word_r[31:16], run_low_r, run_end_r);
    end
  end

  // Read in the id state, write back in the read state; the next word's read
  // comes only after the idle state, so no forwarding is needed.
  assign mem_re = (state_r == psd_pkg::S_ID) && id_ok;
  assign mem_we = (state_r == psd_pkg::S_READ) && (is_row_r != 2'b00);

  always_ff @(posedge clk) begin
    if (mem_we) row_mem[chip_r] <= new_row;
    if (mem_re) rd_data_r <= row_mem[chip_id];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (mem_we) row_vld_r[chip_r] <= 1'b1;
      if (mem_re) rd_vld_r <= row_vld_r[chip_id];
    end
  end

  assign stored_row = rd_vld_r ? rd_data_r : psd_pkg::ROW_UNSET;
  assign row_hi     = is_row_r[0] ? value_r[0] : stored_row;
  assign new_row    = is_row_r[1] ? value_r[1] : row_hi;
  assign sector_ok  = (sector_r != 4'd0) && (sector_r <= 4'(SECTORS));

  function automatic logic [2:0] hit_count(input logic [15:0] col, input logic [1:0] run,
                                           input logic [15:0] row, input logic enable);
    logic [16:0] avail;
    logic [2:0]  n;
    logic [2:0]  cnt;
    avail = 17'(COLUMNS) - {1'b0, col};
    n     = {1'b0, run} + 3'd1;
    if (!enable || ({1'b0, row} >= 17'(ROWS)) || ({1'b0, col} >= 17'(COLUMNS))) cnt = 3'd0;
    else if (avail < 17'(n)) cnt = avail[2:0];
    else cnt = n;
    return cnt;
  endfunction

  assign cnt_nxt[0] = hit_count(value_r[0], run_r[0], stored_row, sector_ok && !is_row_r[0]);
  assign cnt_nxt[1] = hit_count(value_r[1], run_r[1], row_hi, sector_ok && !is_row_r[1]);

  always_ff @(posedge clk) begin
    if (state_r == psd_pkg::S_READ) begin
      cnt_r[0] <= cnt_nxt[0];
      cnt_r[1] <= cnt_nxt[1];
      row_r[0] <= stored_row[9:0];
      row_r[1] <= row_hi[9:0];
    end
  end

  assign emit_load = (state_r == psd_pkg::S_EMIT) && (!out_valid_r || out_ch.ready);
  assign c_plus    = {1'b0, c_r} + 3'd1;
  assign half_done = (c_plus == cnt_r[h_r]);
  assign emit_last = half_done && (h_r || (cnt_r[1] == 3'd0));
  assign col_sum   = value_r[h_r] + 16'(c_r);

  always_ff @(posedge clk) begin
    if (state_r == psd_pkg::S_READ) begin
      h_r <= (cnt_nxt[0] == 3'd0);
      c_r <= 2'd0;
    end else if (emit_load) begin
      if (half_done) begin
        h_r <= 1'b1;
        c_r <= 2'd0;
      end else begin
        c_r <= c_plus[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_ch.hit_sector <= sector_r;
      out_ch.hit_ladder <= ladder_r;
      out_ch.hit_sensor <= sensor_r;
      out_ch.hit_row    <= row_r[h_r];
      out_ch.hit_column <= col_sum[9:0];
      out_ch.last_hit   <= emit_last;
    end
  end

  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= psd_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psd_pkg::S_IDLE: if (in_acc) state_nxt = psd_pkg::S_ID;
      // drop words with a chip id out of range
      psd_pkg::S_ID:   state_nxt = id_ok ? psd_pkg::S_READ : psd_pkg::S_IDLE;
      psd_pkg::S_READ: begin
        if ((cnt_nxt[0] == 3'd0) && (cnt_nxt[1] == 3'd0)) state_nxt = psd_pkg::S_IDLE;
        else state_nxt = psd_pkg::S_EMIT;
      end
      psd_pkg::S_EMIT: if (emit_load && emit_last) state_nxt = psd_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the pixel sparse state decoder.
`timescale 1ns / 1ps

module tb;

  localparam int SECTORS     = 10;
  localparam int LADDERS     = 4;
  localparam int ROWS        = 928;
  localparam int COLUMNS     = 960;
  localparam int CHIPS       = LADDERS * psd_pkg::SENSORS_PER_LADDER;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int CFG_DW      = psd_pkg::CFG_DATA_W;

  typedef struct packed {
    logic [3:0] sector;
    logic [2:0] ladder;
    logic [3:0] sensor;
    logic [9:0] row;
    logic [9:0] column;
    logic       last;
  } pixel_hit_t;

  typedef struct packed {
    logic [3:0] chip_lo;
    logic [4:0] chip_stop;
    logic [6:0] weight;
    logic [3:0] flag_at;
    logic [3:0] run_lo;
    logic [4:0] run_stop;
    logic [3:0] val_lo;
    logic [4:0] val_stop;
  } layout_t;

  // One directed word; when typed, the hits are n adjacent columns from col.
  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  sector;
    logic        typed;
    logic [3:0]  n;
    logic [2:0]  ladder;
    logic [3:0]  sensor;
    logic [9:0]  row;
    logic [9:0]  col;
  } probe_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [psd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [psd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  psd_in_if  in_ch ();
  psd_out_if out_ch ();

  pixel_sparse_state_decoder #(
    .SECTORS (SECTORS),
    .LADDERS (LADDERS),
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #10 clk = ~clk;

  layout_t     layout;
  logic [15:0] row_latch [CHIPS];
  pixel_hit_t  word_hits [$];
  pixel_hit_t  hits_due [$];
  pixel_hit_t  got_hit;
  probe_t      probes [$];
  layout_t     phase_layout [PHASES];
  int          phase_words [PHASES];

  logic steady;
  int   err_count;
  int   words_sent;
  int   hits_checked;
  int   dead_cycles;

  function automatic layout_t mk_layout(input int cl, input int ce, input int wt, input int fl,
                                        input int rl, input int re, input int vl, input int ve);
    layout_t l;
    l.chip_lo   = 4'(cl);
    l.chip_stop = 5'(ce);
    l.weight    = 7'(wt);
    l.flag_at   = 4'(fl);
    l.run_lo    = 4'(rl);
    l.run_stop  = 5'(re);
    l.val_lo    = 4'(vl);
    l.val_stop  = 5'(ve);
    return l;
  endfunction

  function automatic probe_t probe(input logic [31:0] word, input int sector, input bit typed,
                                   input int n, input int ladder, input int sensor,
                                   input int row, input int col);
    probe_t p;
    p.word   = word;
    p.sector = 4'(sector);
    p.typed  = typed;
    p.n      = 4'(n);
    p.ladder = 3'(ladder);
    p.sensor = 4'(sensor);
    p.row    = 10'(row);
    p.col    = 10'(col);
    return p;
  endfunction

  // Bits [lo, stop) of a half; empty and reversed ranges give zero.
  function automatic logic [15:0] bits_of(input logic [15:0] half, input logic [3:0] lo,
                                          input logic [4:0] stop);
    logic [31:0] keep;
    keep = (stop >= 5'd16) ? {16'd0, half} : ({16'd0, half} & ((32'd1 << stop) - 32'd1));
    return 16'(keep >> lo);
  endfunction

  function automatic logic [15:0] put_field(input logic [15:0] half, input int lo,
                                            input int stop, input int v);
    for (int b = lo; b < stop && b < 16; b++) half[b] = v[b-lo];
    return half;
  endfunction

  // Decode one accepted word into word_hits and update the stored rows.
  function automatic void decode_hit_word(input logic [31:0] word, input logic [3:0] sector);
    logic [15:0] half;
    pixel_hit_t  hit;
    int id, chip, run, col;
    word_hits.delete();
    id = int'(bits_of(word[15:0], layout.chip_lo, layout.chip_stop))
       + int'(bits_of(word[31:16], layout.chip_lo, layout.chip_stop)) * int'(layout.weight);
    if (id < 1 || id > CHIPS) return;
    chip = id - 1;
    for (int h = 0; h < 2; h++) begin
      half = (h == 0) ? word[15:0] : word[31:16];
      if (half[layout.flag_at]) begin
        row_latch[chip] = bits_of(half, layout.val_lo, layout.val_stop);
      end else begin
        run = int'(bits_of(half, layout.run_lo, layout.run_stop));
        if (run > 3) run = 3;
        col = int'(bits_of(half, layout.val_lo, layout.val_stop));
        for (int c = 0; c <= run; c++) begin
          if (sector >= 1 && sector <= SECTORS && int'(row_latch[chip]) < ROWS &&
              col + c < COLUMNS) begin
            hit.sector = sector;
            hit.ladder = 3'(chip / 10 + 1);
            hit.sensor = 4'(chip % 10 + 1);
            hit.row    = row_latch[chip][9:0];
            hit.column = 10'(col + c);
            hit.last   = 1'b0;
            word_hits.push_back(hit);
          end
        end
      end
    end
    if (word_hits.size() > 0) begin
      hit = word_hits.pop_back();
      hit.last = 1'b1;
      word_hits.push_back(hit);
    end
  endfunction

  // Mostly well-formed words for the current layout, some raw noise.
  task automatic make_word(output logic [31:0] w, output logic [3:0] s);
    logic [15:0] half [2];
    int roll, id, hi, lo, width, cap, val, is_row;
    roll = int'($urandom_range(0, 99));
    if (roll < 12) begin
      w = $urandom;
      s = 4'($urandom_range(0, 15));
    end else begin
      if ($urandom_range(0, 1) == 0) id = int'($urandom_range(1, 6));
      else if ($urandom_range(0, 19) == 0) id = int'($urandom_range(41, 63));
      else id = int'($urandom_range(1, 40));
      width = (layout.chip_stop > 5'(layout.chip_lo)) ?
              ((layout.chip_stop > 16 ? 16 : int'(layout.chip_stop)) - int'(layout.chip_lo)) : 0;
      cap = (1 << width) - 1;
      hi  = (layout.weight == 0) ? 0 : id / int'(layout.weight);
      if (hi > cap) hi = cap;
      lo  = (id - hi * int'(layout.weight)) & cap;
      for (int h = 0; h < 2; h++) begin
        half[h] = 16'($urandom);
        is_row  = ($urandom_range(0, 99) < 35) ? 1 : 0;
        if (is_row != 0) val = ($urandom_range(0, 9) == 0) ? int'($urandom_range(928, 1023)) :
                                                            int'($urandom_range(0, 927));
        else val = ($urandom_range(0, 6) == 0) ? int'($urandom_range(940, 1023)) :
                                                 int'($urandom_range(0, 959));
        half[h] = put_field(half[h], int'(layout.val_lo), int'(layout.val_stop), val);
        if (is_row == 0)
          half[h] = put_field(half[h], int'(layout.run_lo), int'(layout.run_stop),
                              int'($urandom_range(0, 15)));
        half[h] = put_field(half[h], int'(layout.chip_lo), int'(layout.chip_stop),
                            (h == 0) ? lo : hi);
        half[h][layout.flag_at] = is_row[0];
      end
      w = {half[1], half[0]};
      if (roll < 22) s = ($urandom_range(0, 5) == 0) ? 4'd0 : 4'($urandom_range(11, 15));
      else s = 4'($urandom_range(1, 10));
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_word(input logic [31:0] w, input logic [3:0] s);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.hit_word      <= w;
    in_ch.sector_number <= s;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [psd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psd_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic apply_layout(input layout_t l);
    write_reg(psd_pkg::REG_CHIP_LOW_BIT,     CFG_DW'(l.chip_lo));
    write_reg(psd_pkg::REG_CHIP_END_BIT,     CFG_DW'(l.chip_stop));
    write_reg(psd_pkg::REG_CHIP_HIGH_WEIGHT, CFG_DW'(l.weight));
    write_reg(psd_pkg::REG_ROW_FLAG_BIT,     CFG_DW'(l.flag_at));
    write_reg(psd_pkg::REG_RUN_LOW_BIT,      CFG_DW'(l.run_lo));
    write_reg(psd_pkg::REG_RUN_END_BIT,      CFG_DW'(l.run_stop));
    write_reg(psd_pkg::REG_VALUE_LOW_BIT,    CFG_DW'(l.val_lo));
    write_reg(psd_pkg::REG_VALUE_END_BIT,    CFG_DW'(l.val_stop));
    cfg_we <= 1'b0;
    layout = l;
  endtask

  // Drain the results, then allow for a word still in flight that emits nothing.
  task automatic settle();
    while (hits_due.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic report_error(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_error($sformatf("hit %0d %s: got %0d, expected %0d", hits_checked, name,
                             got, want));
  endtask

  always @(negedge clk) out_ch.ready <= steady || ($urandom_range(0, 99) >= 32);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hits_due.size() == 0) begin
        report_error($sformatf("unexpected hit sector %0d ladder %0d sensor %0d col %0d",
                               out_ch.hit_sector, out_ch.hit_ladder, out_ch.hit_sensor,
                               out_ch.hit_column));
      end else begin
        got_hit = hits_due.pop_front();
        compare_field("sector", int'(out_ch.hit_sector), int'(got_hit.sector));
        compare_field("ladder", int'(out_ch.hit_ladder), int'(got_hit.ladder));
        compare_field("sensor", int'(out_ch.hit_sensor), int'(got_hit.sensor));
        compare_field("row",    int'(out_ch.hit_row),    int'(got_hit.row));
        compare_field("column", int'(out_ch.hit_column), int'(got_hit.column));
        compare_field("last",   int'(out_ch.last_hit),   int'(got_hit.last));
        hits_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) dead_cycles <= 0;
    else dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= STALL_LIMIT) begin
      $display("tb: no transaction for %0d cycles, %0d hits outstanding", dead_cycles,
               hits_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [31:0] w;
    logic [3:0]  s;
    pixel_hit_t  hit;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.hit_word      = '0;
    in_ch.sector_number = '0;
    steady              = 1'b0;
    err_count           = 0;
    words_sent          = 0;
    hits_checked        = 0;
    layout = mk_layout(int'(psd_pkg::RST_CHIP_LOW_BIT), int'(psd_pkg::RST_CHIP_END_BIT),
                       int'(psd_pkg::RST_CHIP_HIGH_WEIGHT), int'(psd_pkg::RST_ROW_FLAG_BIT),
                       int'(psd_pkg::RST_RUN_LOW_BIT), int'(psd_pkg::RST_RUN_END_BIT),
                       int'(psd_pkg::RST_VALUE_LOW_BIT), int'(psd_pkg::RST_VALUE_END_BIT));
    foreach (row_latch[i]) row_latch[i] = psd_pkg::ROW_UNSET;

    // Reset layout: half = {row flag, chip[2:0], run[1:0], value[9:0]}, id = lo + 8*hi.
    probes.push_back(probe(32'h0000_1005, 1,  1, 0, 0, 0, 0,   0));    // row never stored
    probes.push_back(probe(32'h8000_8000, 3,  1, 0, 0, 0, 0,   0));    // id 0, dropped
    probes.push_back(probe(32'h5000_9000, 1,  1, 0, 0, 0, 0,   0));    // id 41, dropped
    probes.push_back(probe(32'h0C00_9005, 1,  1, 4, 1, 1, 5,   0));
    probes.push_back(probe(32'h5FBF_839F, 10, 1, 1, 4, 10, 927, 959)); // run past the edge
    probes.push_back(probe(32'h5000_83A0, 10, 1, 0, 0, 0, 0,   0));    // row 928
    probes.push_back(probe(32'h5000_83FF, 10, 1, 0, 0, 0, 0,   0));
    probes.push_back(probe(32'h0000_100A, 0,  1, 0, 0, 0, 0,   0));    // sector out of range
    probes.push_back(probe(32'h0000_100A, 11, 1, 0, 0, 0, 0,   0));
    probes.push_back(probe(32'h0000_100A, 15, 1, 0, 0, 0, 0,   0));
    probes.push_back(probe(32'h0CC8_1C64, 2,  0, 0, 0, 0, 0,   0));    // eight hits
    probes.push_back(probe(32'h8009_1007, 3,  0, 0, 0, 0, 0,   0));    // column before row
    probes.push_back(probe(32'h0000_1400, 4,  0, 0, 0, 0, 0,   0));
    probes.push_back(probe(32'h0FE8_1FE8, 1,  1, 0, 0, 0, 0,   0));    // columns >= 960
    probes.push_back(probe(32'h8000_9010, 6,  1, 0, 0, 0, 0,   0));    // two row states
    probes.push_back(probe(32'h0000_1802, 7,  0, 0, 0, 0, 0,   0));
    probes.push_back(probe(32'h2DF4_912C, 5,  1, 4, 2, 7, 300, 500));
    probes.push_back(probe(32'hFFFF_FFFF, 15, 1, 0, 0, 0, 0,   0));
    probes.push_back(probe(32'h4000_0C00, 8,  1, 0, 0, 0, 0,   0));
    probes.push_back(probe(32'hC155_4000, 9,  0, 0, 0, 0, 0,   0));
    probes.push_back(probe(32'h4003_4C05, 9,  0, 0, 0, 0, 0,   0));

    phase_layout[0] = layout;
    phase_layout[1] = mk_layout(0,  3,  8,   15, 13, 15, 3,  13);
    phase_layout[2] = mk_layout(12, 16, 1,   0,  11, 12, 1,  11);
    phase_layout[3] = mk_layout(0,  6,  64,  6,  15, 16, 7,  16);
    phase_layout[4] = mk_layout(12, 31, 0,   15, 0,  20, 0,  0);
    phase_layout[5] = mk_layout(15, 0,  8,   15, 10, 12, 0,  10);
    phase_layout[6] = mk_layout(13, 16, 127, 12, 8,  12, 0,  8);
    phase_layout[7] = mk_layout(12, 15, 8,   15, 10, 12, 0,  10);
    phase_words = '{130, 60, 50, 40, 40, 10, 40, 30};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (probes[i]) begin
      send_word(probes[i].word, probes[i].sector);
      decode_hit_word(probes[i].word, probes[i].sector);
      if (probes[i].typed) begin
        for (int k = 0; k < int'(probes[i].n); k++) begin
          hit.sector = probes[i].sector;
          hit.ladder = probes[i].ladder;
          hit.sensor = probes[i].sensor;
          hit.row    = probes[i].row;
          hit.column = probes[i].col + 10'(k);
          hit.last   = (k == int'(probes[i].n) - 1);
          hits_due.push_back(hit);
        end
      end else begin
        foreach (word_hits[j]) hits_due.push_back(word_hits[j]);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        in_ch.valid <= 1'b0;
        settle();
        apply_layout(phase_layout[p]);
      end
      // hold both sides busy for one whole setting
      steady = (p == 1);
      for (int k = 0; k < phase_words[p]; k++) begin
        make_word(w, s);
        send_word(w, s);
        decode_hit_word(w, s);
        foreach (word_hits[j]) hits_due.push_back(word_hits[j]);
      end
    end

    in_ch.valid <= 1'b0;
    while (hits_due.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("tb: %0d words over %0d register settings, %0d hits checked", words_sent,
             PHASES, hits_checked);
    $display("tb: row/column states, dropped ids, bad sectors, rows and columns, extreme layouts");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", err_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
